// File: rtl/core/bfha_pkg.sv
// ----------------------------------------------------------------------------
// Best-fit heap allocator package
// Shared widths, status codes and sequencer states.
// ----------------------------------------------------------------------------
package bfha_pkg;

   localparam int MaxBlocks   = 64;
   localparam int IdxBits     = $clog2(MaxBlocks);
   localparam int CntBits     = IdxBits + 1;
   localparam int AddrBits    = 20;
   localparam int LimBits     = AddrBits + 1;
   localparam int HeaderBytes = 32;
   localparam int WideBits    = AddrBits + 2;

   typedef logic [2:0] status_type;
   localparam status_type ST_WHOLE      = 3'd0;
   localparam status_type ST_SPLIT      = 3'd1;
   localparam status_type ST_GROWN      = 3'd2;
   localparam status_type ST_HEAP_FULL  = 3'd3;
   localparam status_type ST_TABLE_FULL = 3'd4;
   localparam status_type ST_FREED      = 3'd5;
   localparam status_type ST_NULL_FREE  = 3'd6;
   localparam status_type ST_BAD_FREE   = 3'd7;

   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE, S_SCAN_RD, S_SCAN, S_DECIDE, S_FREE_CHK, S_RD_NEXT, S_NEXT,
      S_RD_PREV, S_PREV, S_SHIFT_RD, S_SHIFT_WR, S_RM_RD, S_RM_WR,
      S_FINISH, S_RESP
   } state_type;

   typedef struct packed {
      logic [AddrBits-1:0] start;
      logic [AddrBits-1:0] length;
      logic                is_free;
   } entry_type;

   // Table port: one read address and one write per cycle.
   typedef struct packed {
      logic [IdxBits-1:0] rd_idx;
      logic               wr_en;
      logic [IdxBits-1:0] wr_idx;
      entry_type          wr_data;
   } tbl_ctl_type;

endpackage

// File: rtl/core/bfha_table.sv
// ----------------------------------------------------------------------------
// Block table
// Single-write, single-read memory of heap blocks with a registered read.
// ----------------------------------------------------------------------------
module bfha_table (
   input  logic                 clock,
   input  bfha_pkg::tbl_ctl_type ctl,
   output bfha_pkg::entry_type  rd_data
);
   import bfha_pkg::*;

   entry_type mem [MaxBlocks];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_idx] <= ctl.wr_data;
      end
      rd_data <= mem[ctl.rd_idx];
   end

endmodule

// File: rtl/core/best_fit_heap_allocator_core.sv
// ----------------------------------------------------------------------------
// Best-fit heap allocator core
// Sequencer that scans, splits, grows and merges a table of heap blocks.
// ----------------------------------------------------------------------------
// Channel  | Direction | Payload
// req_     | in        | tuser = req_type, tdata = {req_addr, req_size}
// rsp_     | out       | tdata = {status, result_addr}
// csr_     | in        | data = heap_limit
// One request at a time. The table read is registered, so the scan visits each
// entry in a read state and a compare state (S_SCAN_RD, S_SCAN); inserts and
// removes also move each entry in a read state and a write state. Reset is
// synchronous and empties the table. The response waits in its register until
// rsp_tready; req_tready stays low until then.
// ----------------------------------------------------------------------------
module best_fit_heap_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // [0] req_type
   input  logic [39:0] req_tdata,   // [19:0] req_size, [39:20] req_addr
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [19:0] result_addr, [22:20] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data     // [20:0] heap_limit
);
   import bfha_pkg::*;

   localparam logic [WideBits-1:0] Hdr   = WideBits'(HeaderBytes);
   localparam logic [WideBits-1:0] Space = WideBits'(1) << AddrBits;

   state_type state_ff, state_in;
   logic [LimBits-1:0]  limit_ff, limit_in;
   logic [CntBits-1:0]  count_ff, count_in;
   logic [LimBits-1:0]  brk_ff, brk_in;
   logic                op_ff, op_in;
   logic [AddrBits-1:0] size_ff, size_in, addr_ff, addr_in;
   logic [CntBits-1:0]  idx_ff, idx_in;      // scan / shift pointer
   logic [IdxBits-1:0]  best_ff, best_in;
   logic                found_ff, found_in;
   entry_type           best_e_ff, best_e_in; // target entry copy
   entry_type           hold_ff, hold_in;     // pending insert entry
   logic [IdxBits-1:0]  ins_ff, ins_in;       // insert slot or remove slot
   logic                merge_prev_ff, merge_prev_in;
   logic [AddrBits-1:0] res_addr_ff, res_addr_in;
   status_type          status_ff, status_in;
   tbl_ctl_type         ctl;
   entry_type           rd;

   // Shared adder/comparator operands.
   logic [WideBits-1:0] sum_a, sum_b, sum;
   logic [WideBits-1:0] cap;

   bfha_table u_table (.clock(clock), .ctl(ctl), .rd_data(rd));

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {1'b0, status_ff, res_addr_ff};
   assign sum        = sum_a + sum_b;
   assign cap        = (WideBits'(limit_ff) < Space) ? WideBits'(limit_ff) : Space;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         limit_ff <= LimBits'(1) << AddrBits;
         count_ff <= '0;
         brk_ff   <= '0;
      end else begin
         state_ff <= state_in;
         limit_ff <= limit_in;
         count_ff <= count_in;
         brk_ff   <= brk_in;
      end
      op_ff <= op_in; size_ff <= size_in; addr_ff <= addr_in; idx_ff <= idx_in;
      best_ff <= best_in; found_ff <= found_in; best_e_ff <= best_e_in;
      hold_ff <= hold_in; ins_ff <= ins_in; merge_prev_ff <= merge_prev_in;
      res_addr_ff <= res_addr_in; status_ff <= status_in;
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; brk_in = brk_ff;
      limit_in = (csr_valid && csr_ready) ? csr_data[LimBits-1:0] : limit_ff;
      op_in = op_ff; size_in = size_ff; addr_in = addr_ff; idx_in = idx_ff;
      best_in = best_ff; found_in = found_ff; best_e_in = best_e_ff;
      hold_in = hold_ff; ins_in = ins_ff; merge_prev_in = merge_prev_ff;
      res_addr_in = res_addr_ff; status_in = status_ff;
      ctl = '0;
      ctl.rd_idx = idx_ff[IdxBits-1:0];
      sum_a = '0; sum_b = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tuser;
               size_in = req_tdata[19:0];
               addr_in = req_tdata[39:20];
               idx_in = '0; found_in = 1'b0; res_addr_in = '0;
               if (req_tuser == REQ_FREE && req_tdata[39:20] == '0) begin
                  status_in = ST_NULL_FREE; state_in = S_RESP;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            // Read issued for idx_ff; data valid next cycle.
            if (idx_ff >= count_ff) begin
               state_in = (op_ff == REQ_ALLOC) ? S_DECIDE : S_FINISH;
               status_in = ST_BAD_FREE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            state_in = S_SCAN_RD;
            idx_in = idx_ff + 1'b1;
            if (op_ff == REQ_ALLOC) begin
               if (rd.is_free && rd.length >= size_ff) begin
                  if (!found_ff || rd.length < best_e_ff.length ||
                      rd.length == size_ff) begin
                     best_in = idx_ff[IdxBits-1:0]; best_e_in = rd; found_in = 1'b1;
                  end
                  if (rd.length == size_ff) state_in = S_DECIDE;
               end
            end else begin
               sum_a = WideBits'(rd.start); sum_b = Hdr;
               if (sum == WideBits'(addr_ff)) begin
                  best_in = idx_ff[IdxBits-1:0]; best_e_in = rd;
                  if (rd.is_free) begin
                     status_in = ST_BAD_FREE; state_in = S_FINISH;
                  end else begin
                     state_in = S_FREE_CHK;
                  end
               end
            end
         end
         S_DECIDE: begin
            state_in = S_FINISH;
            if (found_ff) begin
               sum_a = WideBits'(size_ff); sum_b = Hdr;
               if (WideBits'(best_e_ff.length) > sum) begin
                  if (count_ff >= CntBits'(MaxBlocks)) begin
                     status_in = ST_TABLE_FULL;
                  end else begin
                     hold_in.start = best_e_ff.start + AddrBits'(HeaderBytes) + size_ff;
                     hold_in.length = best_e_ff.length - AddrBits'(HeaderBytes) - size_ff;
                     hold_in.is_free = 1'b1;
                     ins_in = best_ff + 1'b1;
                     status_in = ST_SPLIT;
                     res_addr_in = best_e_ff.start + AddrBits'(HeaderBytes);
                     ctl.wr_en = 1'b1; ctl.wr_idx = best_ff;
                     ctl.wr_data = '{start: best_e_ff.start, length: size_ff, is_free: 1'b0};
                     idx_in = count_ff;
                     state_in = S_SHIFT_RD;
                  end
               end else begin
                  status_in = ST_WHOLE;
                  res_addr_in = best_e_ff.start + AddrBits'(HeaderBytes);
                  ctl.wr_en = 1'b1; ctl.wr_idx = best_ff;
                  ctl.wr_data = '{start: best_e_ff.start, length: size_ff, is_free: 1'b0};
               end
            end else if (count_ff >= CntBits'(MaxBlocks)) begin
               status_in = ST_TABLE_FULL;
            end else begin
               sum_a = WideBits'(brk_ff) + Hdr; sum_b = WideBits'(size_ff);
               if (sum > cap || WideBits'(brk_ff) + Hdr >= Space) begin
                  status_in = ST_HEAP_FULL;
               end else begin
                  status_in = ST_GROWN;
                  ctl.wr_en = 1'b1; ctl.wr_idx = count_ff[IdxBits-1:0];
                  ctl.wr_data = '{start: brk_ff[AddrBits-1:0], length: size_ff,
                                  is_free: 1'b0};
                  res_addr_in = brk_ff[AddrBits-1:0] + AddrBits'(HeaderBytes);
                  brk_in = sum[LimBits-1:0];
                  count_in = count_ff + 1'b1;
               end
            end
         end
         S_SHIFT_RD: begin
            // Move entries up from the top until the insert slot is free.
            if (idx_ff == CntBits'(ins_ff)) begin
               ctl.wr_en = 1'b1; ctl.wr_idx = ins_ff; ctl.wr_data = hold_ff;
               count_in = count_ff + 1'b1;
               state_in = S_FINISH;
            end else begin
               ctl.rd_idx = idx_ff[IdxBits-1:0] - 1'b1;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            ctl.wr_en = 1'b1; ctl.wr_idx = idx_ff[IdxBits-1:0]; ctl.wr_data = rd;
            idx_in = idx_ff - 1'b1;
            state_in = S_SHIFT_RD;
         end
         S_FREE_CHK: begin
            best_e_in.is_free = 1'b1;
            ctl.wr_en = 1'b1; ctl.wr_idx = best_ff;
            ctl.wr_data = '{start: best_e_ff.start, length: best_e_ff.length, is_free: 1'b1};
            status_in = ST_FREED;
            merge_prev_in = 1'b0;
            if (CntBits'(best_ff) + 1'b1 < count_ff) begin
               ctl.rd_idx = best_ff + 1'b1;
               state_in = S_NEXT;
            end else begin
               state_in = S_RD_PREV;
            end
         end
         S_RD_NEXT: state_in = S_NEXT;
         S_NEXT: begin
            sum_a = WideBits'(best_e_ff.start) + Hdr; sum_b = WideBits'(best_e_ff.length);
            state_in = S_RD_PREV;
            if (rd.is_free && sum == WideBits'(rd.start)) begin
               best_e_in.length = best_e_ff.length + AddrBits'(HeaderBytes) + rd.length;
               ctl.wr_en = 1'b1; ctl.wr_idx = best_ff;
               ctl.wr_data = '{start: best_e_ff.start,
                               length: best_e_ff.length + AddrBits'(HeaderBytes) + rd.length,
                               is_free: 1'b1};
               ins_in = best_ff + 1'b1;
               idx_in = CntBits'(best_ff) + 1'b1;
               state_in = S_RM_RD;
            end
         end
         S_RD_PREV: begin
            if (merge_prev_ff || best_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               ctl.rd_idx = best_ff - 1'b1;
               state_in = S_PREV;
            end
         end
         S_PREV: begin
            sum_a = WideBits'(rd.start) + Hdr; sum_b = WideBits'(rd.length);
            state_in = S_FINISH;
            if (rd.is_free && sum == WideBits'(best_e_ff.start)) begin
               ctl.wr_en = 1'b1; ctl.wr_idx = best_ff - 1'b1;
               ctl.wr_data = '{start: rd.start,
                               length: rd.length + AddrBits'(HeaderBytes) + best_e_ff.length,
                               is_free: 1'b1};
               merge_prev_in = 1'b1;
               ins_in = best_ff;
               idx_in = CntBits'(best_ff);
               state_in = S_RM_RD;
            end
         end
         S_RM_RD: begin
            // Close the gap at ins_ff by moving higher entries down.
            if (idx_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_RD_PREV;
            end else begin
               ctl.rd_idx = idx_ff[IdxBits-1:0] + 1'b1;
               state_in = S_RM_WR;
            end
         end
         S_RM_WR: begin
            ctl.wr_en = 1'b1; ctl.wr_idx = idx_ff[IdxBits-1:0]; ctl.wr_data = rd;
            idx_in = idx_ff + 1'b1;
            state_in = S_RM_RD;
         end
         S_FINISH: state_in = S_RESP;
         S_RESP: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

endmodule
